// File: hdl/dictionary_word_break_checker_macros.svh
// assertion macros for the dictionary word break checker
`ifndef DICTIONARY_WORD_BREAK_CHECKER_MACROS_SVH
`define DICTIONARY_WORD_BREAK_CHECKER_MACROS_SVH
`ifndef SYNTHESIS
`define DWB_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dwb check failed: name");
`define DWB_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dwb forbidden condition: name");
`else
`define DWB_ASSERT(name, prop)
`define DWB_NEVER(name, cond)
`endif
`endif

// File: hdl/dwb_pkg.sv
// shared constants and types of the dictionary word break checker
package dwb_pkg;

    localparam int MAX_WORDS    = 16;
    localparam int MAX_WORD_LEN = 16;

    // stored word length, 0 .. MAX_WORD_LEN
    localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
    // loading length saturates at MAX_WORD_LEN + 1
    localparam int LLEN_W = $clog2(MAX_WORD_LEN + 2);
    // word count, 0 .. MAX_WORDS
    localparam int CNT_W  = $clog2(MAX_WORDS + 1);

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_DICT  = 2'd1;
    localparam logic [1:0] REQ_TEXT  = 2'd2;

    typedef logic [MAX_WORD_LEN-1:0][7:0] char_window_t;

    typedef struct packed {
        logic             clear;
        logic             load;
        logic             commit;
        logic [7:0]       symbol;
        logic [LEN_W-1:0] length;
    } cell_ctrl_t;

endpackage

// File: hdl/dwb_stream_if.sv
// request and result channel interfaces
interface dwb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] symbol;
    logic       last_of_unit;

    modport source (output valid, output req_type, output symbol, output last_of_unit,
                    input ready);
    modport sink   (input valid, input req_type, input symbol, input last_of_unit,
                    output ready);
endinterface

interface dwb_res_if;
    logic valid;
    logic ready;
    logic prefix_segmentable;
    logic text_done;
    logic dict_overflow;

    modport source (output valid, output prefix_segmentable, output text_done,
                    output dict_overflow, input ready);
    modport sink   (input valid, input prefix_segmentable, input text_done,
                    input dict_overflow, output ready);
endinterface

// File: hdl/dwb_word_cell.sv
// one dictionary slot: stored word, its length and the match against recent text
module dwb_word_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dwb_pkg::cell_ctrl_t   ctrl,
    input  dwb_pkg::char_window_t window,
    input  logic [dwb_pkg::MAX_WORD_LEN-1:0] reach,
    output logic                  hit
);
    import dwb_pkg::*;

    // characters shift in, so the last one sits at position 0 and lines up
    // with the newest text character
    char_window_t        chars_reg;
    char_window_t        chars_next;
    logic [LEN_W-1:0]    len_reg;
    logic [MAX_WORD_LEN-1:0] pos_ok;
    logic                reach_ok;

    always_comb
    begin
        chars_next[0] = ctrl.symbol;
        for (int k = 1; k < MAX_WORD_LEN; k++)
        begin
            chars_next[k] = chars_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            chars_reg <= chars_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            len_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            len_reg <= ctrl.length;
        end
    end

    always_comb
    begin
        reach_ok = 1'b0;
        for (int k = 0; k < MAX_WORD_LEN; k++)
        begin
            pos_ok[k] = (chars_reg[k] == window[k]) || (LEN_W'(k) >= len_reg);
            if (len_reg == LEN_W'(k + 1))
            begin
                reach_ok = reach[k];
            end
        end
    end

    // a zero length never selects a reach bit, so empty slots never hit
    assign hit = reach_ok && (&pos_ok);

endmodule

// File: hdl/dictionary_word_break_checker.sv
// top level of the dictionary word break checker
//
//  channel  dir  payload                                          role
//  req      in   req_type, symbol, last_of_unit                   clear / dict char / text char
//  res      out  prefix_segmentable, text_done, dict_overflow     one word per text char
//
// one request word per cycle unless a held result stalls a text word; a word sits in
// the input register, where all slots compare against the text window at
// once, then the result lands in the output register.
// reset clears counts, lengths, history and flags at once; no clearing pass.
// a held result stalls the input register only when it holds a text word.
module dictionary_word_break_checker (
    input  logic         clk,
    input  logic         rst_n,
    dwb_req_if.sink      req,
    dwb_res_if.source    res
);
    import dwb_pkg::*;

    `include "dictionary_word_break_checker_macros.svh"

    // input register
    logic             s1_valid_reg;
    logic [1:0]       s1_type_reg;
    logic [7:0]       s1_sym_reg;
    logic             s1_last_reg;

    // block state
    logic [CNT_W-1:0]        word_count_reg;
    logic [CNT_W-1:0]        word_count_next;
    logic [LLEN_W-1:0]       load_len_reg;
    logic [LLEN_W-1:0]       load_len_next;
    char_window_t            recent_reg;
    char_window_t            recent_next;
    logic [MAX_WORD_LEN-1:0] reach_reg;
    logic [MAX_WORD_LEN-1:0] reach_next;
    logic                    ovf_reg;
    logic                    ovf_next;

    // result register
    logic res_valid_reg;
    logic res_seg_reg;
    logic res_done_reg;
    logic res_ovf_reg;

    logic s1_text;
    logic s1_dict;
    logic s1_clear;
    logic s1_stall;
    logic s1_go;
    logic fits;
    logic has_slot;
    logic [LLEN_W-1:0] new_len;
    logic do_load;
    logic do_commit;
    logic any_hit;

    char_window_t            window;
    cell_ctrl_t              cell_ctrl [MAX_WORDS];
    logic [MAX_WORDS-1:0]    cell_hit;
    logic [MAX_WORDS-1:0]    cell_load;

    assign s1_text  = s1_valid_reg && (s1_type_reg == REQ_TEXT);
    assign s1_dict  = s1_valid_reg && (s1_type_reg == REQ_DICT);
    assign s1_clear = s1_valid_reg && (s1_type_reg == REQ_CLEAR);
    assign s1_stall = s1_text && res_valid_reg && !res.ready;
    assign s1_go    = s1_valid_reg && !s1_stall;
    assign req.ready = !s1_valid_reg || !s1_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_type_reg <= req.req_type;
            s1_sym_reg  <= req.symbol;
            s1_last_reg <= req.last_of_unit;
        end
    end

    // dictionary loading
    assign fits     = load_len_reg < LLEN_W'(MAX_WORD_LEN);
    assign has_slot = word_count_reg < CNT_W'(MAX_WORDS);
    assign new_len  = fits ? (load_len_reg + LLEN_W'(1)) : LLEN_W'(MAX_WORD_LEN + 1);
    assign do_load  = s1_go && s1_dict && fits && has_slot;
    assign do_commit = s1_go && s1_dict && s1_last_reg && has_slot
                       && (new_len <= LLEN_W'(MAX_WORD_LEN));

    // text window with the new character in front
    always_comb
    begin
        window[0] = s1_sym_reg;
        for (int k = 1; k < MAX_WORD_LEN; k++)
        begin
            window[k] = recent_reg[k-1];
        end
    end

    for (genvar w = 0; w < MAX_WORDS; w++)
    begin : g_cell
        assign cell_load[w] = do_load && (word_count_reg == CNT_W'(w));

        always_comb
        begin
            cell_ctrl[w].clear  = s1_go && s1_clear;
            cell_ctrl[w].load   = cell_load[w];
            cell_ctrl[w].commit = do_commit && (word_count_reg == CNT_W'(w));
            cell_ctrl[w].symbol = s1_sym_reg;
            cell_ctrl[w].length = new_len[LEN_W-1:0];
        end

        dwb_word_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (cell_ctrl[w]),
            .window (window),
            .reach  (reach_reg),
            .hit    (cell_hit[w])
        );
    end

    assign any_hit = |cell_hit;

    always_comb
    begin
        word_count_next = word_count_reg;
        load_len_next   = load_len_reg;
        recent_next     = recent_reg;
        reach_next      = reach_reg;
        ovf_next        = ovf_reg;
        if (s1_go)
        begin
            case (s1_type_reg)
                REQ_CLEAR:
                begin
                    word_count_next = '0;
                    load_len_next   = '0;
                    ovf_next        = 1'b0;
                    recent_next     = '0;
                    reach_next      = MAX_WORD_LEN'(1);
                end
                REQ_DICT:
                begin
                    load_len_next = new_len;
                    if (s1_last_reg)
                    begin
                        load_len_next = '0;
                        if (do_commit)
                        begin
                            word_count_next = word_count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                REQ_TEXT:
                begin
                    if (s1_last_reg)
                    begin
                        // history back to the empty prefix for the next text
                        recent_next = '0;
                        reach_next  = MAX_WORD_LEN'(1);
                    end
                    else
                    begin
                        recent_next = window;
                        reach_next[0] = any_hit;
                        for (int k = 1; k < MAX_WORD_LEN; k++)
                        begin
                            reach_next[k] = reach_reg[k-1];
                        end
                    end
                end
                default:
                begin
                    word_count_next = word_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= '0;
            load_len_reg   <= '0;
            recent_reg     <= '0;
            reach_reg      <= MAX_WORD_LEN'(1);
            ovf_reg        <= 1'b0;
        end
        else
        begin
            word_count_reg <= word_count_next;
            load_len_reg   <= load_len_next;
            recent_reg     <= recent_next;
            reach_reg      <= reach_next;
            ovf_reg        <= ovf_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_text)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_text)
        begin
            res_seg_reg  <= any_hit;
            res_done_reg <= s1_last_reg;
            res_ovf_reg  <= ovf_reg;
        end
    end

    assign res.valid              = res_valid_reg;
    assign res.prefix_segmentable = res_seg_reg;
    assign res.text_done          = res_done_reg;
    assign res.dict_overflow      = res_ovf_reg;

    `DWB_NEVER(a_count_range, word_count_reg > CNT_W'(MAX_WORDS))
    `DWB_NEVER(a_load_len_range, load_len_reg > LLEN_W'(MAX_WORD_LEN + 1))
    `DWB_ASSERT(a_one_cell_loads, $onehot0(cell_load))
    `DWB_ASSERT(a_text_gives_result, (s1_go && s1_text) |=> res_valid_reg)
    `DWB_ASSERT(a_history_reset, (s1_go && s1_text && s1_last_reg) |=>
                (reach_reg == MAX_WORD_LEN'(1)))

endmodule

// File: verif/testbench.sv
// self-checking testbench of the dictionary word break checker
module testbench;
    import dwb_pkg::*;

    // request code that the block ignores
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic segmentable;
        logic done;
        logic overflow;
    } prefix_result_t;

    logic clk;
    logic rst_n;

    dwb_req_if req_ch ();
    dwb_res_if res_ch ();

    dictionary_word_break_checker u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // predicted dictionary and text history
    logic [7:0]        dict_chars [MAX_WORDS][MAX_WORD_LEN];
    logic [LEN_W-1:0]  dict_len [MAX_WORDS];
    logic [CNT_W-1:0]  dict_count;
    logic [LLEN_W-1:0] load_len;
    logic [7:0]        text_window [MAX_WORD_LEN];
    logic              reach [0:MAX_WORD_LEN];
    logic              dropped_word;

    prefix_result_t pending_prefix_results[$];

    int  mismatches;
    int  words_sent;
    int  results_checked;
    int  texts_closed;
    int  overflow_seen;
    bit  sender_gaps;
    bit  receiver_gaps;
    bit  long_hold_req;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void clear_history();
        for (int i = 0; i < MAX_WORD_LEN; i++)
            text_window[i] = 8'h00;
        for (int i = 0; i <= MAX_WORD_LEN; i++)
            reach[i] = 1'b0;
        reach[0] = 1'b1;
    endfunction

    function automatic void track_word_break(input logic [1:0] kind, input logic [7:0] sym,
                                             input logic last);
        prefix_result_t want;
        logic hit;
        logic matched;
        int len;
        case (kind)
            REQ_CLEAR:
            begin
                for (int w = 0; w < MAX_WORDS; w++)
                    dict_len[w] = '0;
                dict_count   = '0;
                load_len     = '0;
                dropped_word = 1'b0;
                clear_history();
            end
            REQ_DICT:
            begin
                if (load_len < MAX_WORD_LEN)
                begin
                    if (dict_count < MAX_WORDS)
                        dict_chars[dict_count][load_len] = sym;
                    load_len = load_len + 1'b1;
                end
                else
                begin
                    load_len = LLEN_W'(MAX_WORD_LEN + 1);
                end
                if (last)
                begin
                    if (load_len > MAX_WORD_LEN || dict_count >= MAX_WORDS)
                    begin
                        dropped_word = 1'b1;
                    end
                    else
                    begin
                        dict_len[dict_count] = load_len;
                        dict_count = dict_count + 1'b1;
                    end
                    load_len = '0;
                end
            end
            REQ_TEXT:
            begin
                for (int j = MAX_WORD_LEN - 1; j > 0; j--)
                    text_window[j] = text_window[j-1];
                text_window[0] = sym;
                hit = 1'b0;
                for (int w = 0; w < dict_count; w++)
                begin
                    len = dict_len[w];
                    // reach is still indexed from before this character
                    if (len != 0 && reach[len-1])
                    begin
                        matched = 1'b1;
                        for (int j = 0; j < len; j++)
                            if (dict_chars[w][j] != text_window[len-1-j])
                                matched = 1'b0;
                        if (matched)
                            hit = 1'b1;
                    end
                end
                for (int k = MAX_WORD_LEN; k > 0; k--)
                    reach[k] = reach[k-1];
                reach[0] = hit;
                want.segmentable = hit;
                want.done        = last;
                want.overflow    = dropped_word;
                pending_prefix_results = {pending_prefix_results, want};
                if (last)
                    clear_history();
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] pick_symbol(input bit wide);
        if (wide)
            return 8'($urandom_range(0, 255));
        return 8'h61 + 8'($urandom_range(0, 2));
    endfunction

    task automatic send_word(input logic [1:0] kind, input logic [7:0] sym, input logic last);
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.symbol       <= sym;
        req_ch.last_of_unit <= last;
        do
            @(posedge clk);
        while (!req_ch.ready);
        track_word_break(kind, sym, last);
        if (kind != REQ_UNUSED)
            words_sent++;
    endtask

    task automatic load_word(input int len, input bit wide);
        for (int j = 0; j < len; j++)
            send_word(REQ_DICT, pick_symbol(wide), j == len - 1);
    endtask

    task automatic test_basic_words();
        send_word(REQ_CLEAR, 8'hff, 1'b1);
        send_word(REQ_DICT, 8'h00, 1'b1);
        send_word(REQ_DICT, 8'hff, 1'b1);
        send_word(REQ_DICT, "a", 1'b0);
        send_word(REQ_DICT, "b", 1'b1);
        send_word(REQ_UNUSED, 8'h5a, 1'b1);
        send_word(REQ_TEXT, 8'h00, 1'b0);
        send_word(REQ_TEXT, 8'hff, 1'b0);
        send_word(REQ_TEXT, "a", 1'b0);
        send_word(REQ_TEXT, "b", 1'b1);
        // text starts before the word that completes it is added
        send_word(REQ_TEXT, "a", 1'b0);
        send_word(REQ_DICT, "a", 1'b1);
        send_word(REQ_TEXT, "b", 1'b0);
        send_word(REQ_TEXT, "a", 1'b1);
        send_word(REQ_TEXT, 8'hff, 1'b1);
        // clear in the middle of a text
        send_word(REQ_TEXT, "a", 1'b0);
        send_word(REQ_CLEAR, 8'h00, 1'b0);
        send_word(REQ_TEXT, "a", 1'b1);
    endtask

    task automatic test_dictionary_limits();
        send_word(REQ_CLEAR, 8'h00, 1'b0);
        load_word(MAX_WORD_LEN, 1'b1);
        for (int j = 0; j < MAX_WORD_LEN; j++)
            send_word(REQ_TEXT, dict_chars[0][j], j == MAX_WORD_LEN - 1);
        // one character too many: word dropped
        load_word(MAX_WORD_LEN + 1, 1'b1);
        for (int j = 0; j < MAX_WORD_LEN; j++)
            send_word(REQ_TEXT, dict_chars[0][j], j == MAX_WORD_LEN - 1);
        send_word(REQ_CLEAR, 8'h00, 1'b1);
        for (int w = 0; w < MAX_WORDS; w++)
            load_word(1, 1'b1);
        load_word(2, 1'b1);
        for (int w = 0; w < 4; w++)
            send_word(REQ_TEXT, dict_chars[$urandom_range(0, MAX_WORDS - 1)][0], w == 3);
    endtask

    task automatic test_backpressure();
        send_word(REQ_CLEAR, 8'h00, 1'b0);
        for (int w = 0; w < 3; w++)
            load_word($urandom_range(1, 2), 1'b0);
        sender_gaps   = 1'b0;
        long_hold_req = 1'b1;
        for (int j = 0; j < 40; j++)
            send_word(REQ_TEXT, pick_symbol(1'b0), j == 39);
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_sessions(input int target, input int quiet_after);
        logic [7:0] text_q[$];
        int n_words;
        int n_texts;
        int n_pieces;
        int len;
        int w;
        bit wide;
        while (words_sent < target)
        begin
            if (words_sent >= quiet_after)
            begin
                sender_gaps   = 1'b0;
                receiver_gaps = 1'b0;
            end
            wide = ($urandom_range(0, 5) == 0);
            // now and then keep the old dictionary so it can fill up
            if ($urandom_range(0, 9) != 0)
                send_word(REQ_CLEAR, pick_symbol(1'b1), 1'($urandom_range(0, 1)));
            n_words = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 5);
            for (int i = 0; i < n_words; i++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 17) : $urandom_range(1, 4);
                load_word(len, wide);
            end
            n_texts = $urandom_range(1, 3);
            for (int t = 0; t < n_texts; t++)
            begin
                text_q.delete();
                if (dict_count == 0 || $urandom_range(0, 4) == 0)
                begin
                    len = $urandom_range(1, 20);
                    for (int j = 0; j < len; j++)
                        text_q = {text_q, pick_symbol(wide)};
                end
                else
                begin
                    // well-formed text from stored words, with the odd corrupt character
                    n_pieces = $urandom_range(1, 5);
                    for (int p = 0; p < n_pieces; p++)
                    begin
                        w = $urandom_range(0, dict_count - 1);
                        for (int j = 0; j < dict_len[w]; j++)
                            text_q = {text_q, (($urandom_range(0, 24) == 0) ?
                                               pick_symbol(1'b1) : dict_chars[w][j])};
                    end
                end
                for (int j = 0; j < text_q.size(); j++)
                begin
                    case ($urandom_range(0, 59))
                        0: send_word(REQ_UNUSED, pick_symbol(1'b1), 1'($urandom_range(0, 1)));
                        1: load_word($urandom_range(1, 2), wide);
                        2: send_word(REQ_CLEAR, pick_symbol(1'b1), 1'($urandom_range(0, 1)));
                        default: ;
                    endcase
                    send_word(REQ_TEXT, text_q[j], j == text_q.size() - 1);
                end
            end
        end
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = 60;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (receiver_gaps && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        prefix_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_prefix_results.size() == 0)
            begin
                $error("result word with no prediction waiting");
                mismatches++;
            end
            else
            begin
                want = pending_prefix_results.pop_front();
                results_checked++;
                if (res_ch.text_done)
                    texts_closed++;
                if (res_ch.dict_overflow)
                    overflow_seen++;
                if (res_ch.prefix_segmentable !== want.segmentable)
                begin
                    $error("prefix_segmentable: expected %0d, got %0d",
                           want.segmentable, res_ch.prefix_segmentable);
                    mismatches++;
                end
                if (res_ch.text_done !== want.done)
                begin
                    $error("text_done: expected %0d, got %0d", want.done, res_ch.text_done);
                    mismatches++;
                end
                if (res_ch.dict_overflow !== want.overflow)
                begin
                    $error("dict_overflow: expected %0d, got %0d",
                           want.overflow, res_ch.dict_overflow);
                    mismatches++;
                end
            end
        end
    end

    initial begin : run
        int waited;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_CLEAR;
        req_ch.symbol       <= 8'h00;
        req_ch.last_of_unit <= 1'b0;
        mismatches      = 0;
        words_sent      = 0;
        results_checked = 0;
        texts_closed    = 0;
        overflow_seen   = 0;
        sender_gaps     = 1'b1;
        receiver_gaps   = 1'b1;
        long_hold_req   = 1'b0;
        for (int w = 0; w < MAX_WORDS; w++)
            dict_len[w] = '0;
        dict_count   = '0;
        load_len     = '0;
        dropped_word = 1'b0;
        clear_history();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_words();
        test_dictionary_limits();
        test_backpressure();
        test_random_sessions(1400, 1200);
        req_ch.valid <= 1'b0;

        waited = 0;
        while (pending_prefix_results.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_prefix_results.size() != 0)
        begin
            $error("%0d predicted results never arrived", pending_prefix_results.size());
            mismatches += pending_prefix_results.size();
        end
        repeat (8) @(posedge clk);

        $display("run sent %0d request words and checked %0d prefix results over %0d texts",
                 words_sent, results_checked, texts_closed);
        $display("%0d results carried the dropped-word flag", overflow_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
